// ===== hw/rtl/eua_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eua_pkg: shared types and constants for the encoder unwrap unit
// Frame and angle widths, register indexes, controller states and the
// command / status groups between controller and datapath.
// ----------------------------------------------------------------------------
package eua_pkg;

  // Encoder and frame geometry
  localparam int ANGLE_W        = 12;
  localparam int ANGLE_COUNTS   = 4096;
  localparam int FRAME_BITS     = 24;
  localparam int DIFF_W         = ANGLE_W + 2;

  localparam logic signed [FRAME_BITS-1:0] FRAME_MAX = {1'b0, {(FRAME_BITS-1){1'b1}}};
  localparam logic signed [FRAME_BITS-1:0] FRAME_MIN = {1'b1, {(FRAME_BITS-1){1'b0}}};

  localparam logic signed [DIFF_W-1:0] COUNTS_S = DIFF_W'(ANGLE_COUNTS);
  localparam logic signed [DIFF_W-1:0] HALF_S   = DIFF_W'(ANGLE_COUNTS / 2);

  // Field widths
  localparam int SPAN_W   = 23;
  localparam int AXIS_W   = 16;
  localparam int TRAVEL_W = 17;
  localparam int PROD_W   = TRAVEL_W + AXIS_W;

  localparam logic [TRAVEL_W-1:0] TRAVEL_FULL = 17'd65536;
  localparam logic [TRAVEL_W-1:0] TRAVEL_HALF = 17'd32768;
  localparam logic [AXIS_W-1:0]   AXIS_RESET  = 16'd32767;
  localparam logic [PROD_W-1:0]   ROUND_HALF  = 33'd32768;

  // Travel divider: 17 quotient bits, remainder one bit over the frame
  localparam int DIV_R_W   = FRAME_BITS + 1;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd16;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 23;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STORED_MIN = 4'd0,
    CFG_STORED_SPAN = 4'd1,
    CFG_MAX_STEP   = 4'd2,
    CFG_OUT_MIN    = 4'd3,
    CFG_OUT_MAX    = 4'd4,
    CFG_INVERT     = 4'd5,
    CFG_BTN_THR    = 4'd6,
    CFG_BTN_HYST   = 4'd7
  } cfg_idx_t;

  // How the travel fraction is formed for the current sample
  typedef enum logic [1:0] {
    TM_CENTER,
    TM_ZERO,
    TM_FULL,
    TM_DIVIDE
  } travel_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UNWRAP,
    ST_RANGE,
    ST_PREP,
    ST_DIV,
    ST_SCALE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic unwrap;
    logic range_upd;
    logic prep;
    logic div_step;
    logic scale;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_sample;
    logic div_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/encoder_unwrap_autocal_axis_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_unwrap_autocal_axis_unit: encoder unwrap with range autocalibration
// Input channel (in_valid/in_ready) carries one request: an angle sample
// with its read_ok flag, or a calibration reset (req_type = 1). Each
// request gives exactly one result on the output channel
// (out_valid/out_ready): axis value, Q16 travel, virtual button, range flag.
// Configuration writes use cfg_valid/cfg_ready with cfg_index/cfg_data;
// cfg_ready is always high. Write registers only while the unit is idle.
// Sequence: a good sample passes unwrap, range update, divider setup, the
// 17-step restoring divider for the travel fraction, scaling and result
// write; a failed read or calibration reset goes from unwrap straight to
// result write. One request is in flight at a time;
// in_ready is high whenever the sequencer is idle, also while a finished
// result still waits in the output register.
// A stalled receiver holds the result in the output register; the next
// request then waits at its final step until that result is taken.
// Reset (rst, synchronous) clears the frame, empties the calibration
// range, restores register defaults and sets the held output to mid-scale.
// ----------------------------------------------------------------------------
module encoder_unwrap_autocal_axis_unit import eua_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // request
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [ANGLE_W-1:0]    raw_angle,
  input  logic                  read_ok,
  // result
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [AXIS_W-1:0]     axis_value,
  output logic [TRAVEL_W-1:0]   travel,
  output logic                  virtual_button,
  output logic                  range_valid
);

  cmd_t    cmd;
  status_t status;

  eua_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  eua_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_type       (req_type),
    .raw_angle      (raw_angle),
    .read_ok        (read_ok),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .axis_value     (axis_value),
    .travel         (travel),
    .virtual_button (virtual_button),
    .range_valid    (range_valid),
    .cmd            (cmd),
    .status         (status)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/eua_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eua_ctrl: sequencing controller
// Walks one request through unwrap, range update, prep, divide, scale and
// result write (non-sample requests skip to it), one command group per state.
// ----------------------------------------------------------------------------
module eua_ctrl import eua_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_UNWRAP;
      end
      ST_UNWRAP: begin
        state_next = status.is_sample ? ST_RANGE : ST_FINISH;
      end
      ST_RANGE:  state_next = ST_PREP;
      ST_PREP:   state_next = ST_DIV;
      ST_DIV: begin
        if (status.div_last) state_next = ST_SCALE;
      end
      ST_SCALE:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_UNWRAP: cmd.unwrap    = 1'b1;
      ST_RANGE:  cmd.range_upd = 1'b1;
      ST_PREP:   cmd.prep      = 1'b1;
      ST_DIV:    cmd.div_step  = 1'b1;
      ST_SCALE:  cmd.scale     = 1'b1;
      ST_FINISH: cmd.finish    = status.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/eua_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eua_dp: unwrap, calibration range, travel divider and axis scaling
// Holds the configuration registers, the continuous frame state, a
// restoring divider for the Q16 travel and the output register.
// ----------------------------------------------------------------------------
module eua_dp import eua_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // request payload
  input  logic                  req_type,
  input  logic [ANGLE_W-1:0]    raw_angle,
  input  logic                  read_ok,
  // result
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [AXIS_W-1:0]     axis_value,
  output logic [TRAVEL_W-1:0]   travel,
  output logic                  virtual_button,
  output logic                  range_valid,
  // control
  input  cmd_t                  cmd,
  output status_t               status
);

  // Configuration registers
  logic [ANGLE_W-1:0]  stored_min_abs;
  logic [SPAN_W-1:0]   stored_span;
  logic [ANGLE_W-1:0]  max_step;
  logic [AXIS_W-1:0]   out_min;
  logic [AXIS_W-1:0]   out_max;
  logic                invert;
  logic [TRAVEL_W-1:0] button_threshold;
  logic [TRAVEL_W-1:0] button_hysteresis;

  // Frame state
  logic signed [FRAME_BITS-1:0] cont_angle;
  logic signed [FRAME_BITS-1:0] range_low;
  logic signed [FRAME_BITS-1:0] range_high;
  logic [ANGLE_W-1:0]           prev_raw;
  logic                         seeded;
  logic [AXIS_W-1:0]            held_output;
  logic [TRAVEL_W-1:0]          held_travel;
  logic                         button_latch;

  // Latched request
  logic                req_q;
  logic [ANGLE_W-1:0]  raw_q;
  logic                ok_q;
  logic                upd_range;

  // Divider and scaling
  travel_mode_t        tmode;
  logic [DIV_R_W-1:0]  div_r;
  logic [DIV_R_W-1:0]  div_d;
  logic [TRAVEL_W-1:0] div_lo;
  logic [TRAVEL_W-1:0] quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [TRAVEL_W-1:0] trav_q;
  logic [PROD_W-1:0]   prod;

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_min_abs    <= '0;
      stored_span       <= '0;
      max_step          <= 12'd256;
      out_min           <= '0;
      out_max           <= 16'd65535;
      invert            <= 1'b0;
      button_threshold  <= 17'd49152;
      button_hysteresis <= 17'd3277;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STORED_MIN:  stored_min_abs    <= cfg_data[ANGLE_W-1:0];
        CFG_STORED_SPAN: stored_span       <= cfg_data[SPAN_W-1:0];
        CFG_MAX_STEP:    max_step          <= cfg_data[ANGLE_W-1:0];
        CFG_OUT_MIN:     out_min           <= cfg_data[AXIS_W-1:0];
        CFG_OUT_MAX:     out_max           <= cfg_data[AXIS_W-1:0];
        CFG_INVERT:      invert            <= cfg_data[0];
        CFG_BTN_THR:     button_threshold  <= cfg_data[TRAVEL_W-1:0];
        CFG_BTN_HYST:    button_hysteresis <= cfg_data[TRAVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req_type;
      raw_q <= raw_angle;
      ok_q  <= read_ok;
    end
  end

  logic have_stored;
  assign have_stored = (stored_span != '0);

  // Seed values from a stored calibration
  logic [ANGLE_W-1:0]    seed_rel;
  logic [ANGLE_W:0]      seed_cont;
  logic [FRAME_BITS-1:0] seed_hi_sum;
  logic signed [FRAME_BITS-1:0] seed_hi;
  always_comb begin
    seed_rel    = raw_q - stored_min_abs;
    seed_cont   = {1'b0, stored_min_abs} + {1'b0, seed_rel};
    seed_hi_sum = FRAME_BITS'(stored_min_abs) + FRAME_BITS'(stored_span);
    seed_hi     = seed_hi_sum[FRAME_BITS-1] ? FRAME_MAX : $signed(seed_hi_sum);
  end

  // Unwrap the seam and saturate the frame
  logic signed [DIFF_W-1:0]     d_raw;
  logic signed [DIFF_W-1:0]     d_wrap;
  logic [DIFF_W-1:0]            d_mag;
  logic                         step_ok;
  logic signed [FRAME_BITS:0]   cont_sum;
  logic signed [FRAME_BITS-1:0] cont_sat;
  always_comb begin
    d_raw = $signed({2'b00, raw_q}) - $signed({2'b00, prev_raw});
    if (d_raw > HALF_S) begin
      d_wrap = d_raw - COUNTS_S;
    end else if (d_raw < -HALF_S) begin
      d_wrap = d_raw + COUNTS_S;
    end else begin
      d_wrap = d_raw;
    end
    d_mag    = d_wrap[DIFF_W-1] ? $unsigned(-d_wrap) : $unsigned(d_wrap);
    step_ok  = (d_mag <= {2'b00, max_step});
    cont_sum = {cont_angle[FRAME_BITS-1], cont_angle}
             + {{(FRAME_BITS+1-DIFF_W){d_wrap[DIFF_W-1]}}, d_wrap};
    if (cont_sum[FRAME_BITS] != cont_sum[FRAME_BITS-1]) begin
      cont_sat = cont_sum[FRAME_BITS] ? FRAME_MIN : FRAME_MAX;
    end else begin
      cont_sat = cont_sum[FRAME_BITS-1:0];
    end
  end

  // Travel setup: numerator, span and end cases
  logic signed [FRAME_BITS:0] num;
  logic signed [FRAME_BITS:0] den_full;
  logic [FRAME_BITS-1:0]      den;
  logic                       has_range;
  always_comb begin
    num       = {cont_angle[FRAME_BITS-1], cont_angle} - {range_low[FRAME_BITS-1], range_low};
    den_full  = {range_high[FRAME_BITS-1], range_high} - {range_low[FRAME_BITS-1], range_low};
    den       = den_full[FRAME_BITS-1:0];
    has_range = (range_high > range_low);
  end

  // One restoring divide step
  logic [DIV_R_W:0] div_rs;
  logic [DIV_R_W:0] div_diff;
  logic             div_ge;
  always_comb begin
    div_rs   = {div_r, div_lo[TRAVEL_W-1]};
    div_diff = div_rs - {1'b0, div_d};
    div_ge   = (div_rs >= {1'b0, div_d});
  end

  // Final travel and scale product
  logic [TRAVEL_W-1:0] t_sel;
  logic [TRAVEL_W-1:0] t_fin;
  logic                out_up;
  logic [AXIS_W-1:0]   out_span;
  always_comb begin
    case (tmode)
      TM_ZERO:   t_sel = '0;
      TM_FULL:   t_sel = TRAVEL_FULL;
      TM_DIVIDE: t_sel = quo;
      default:   t_sel = TRAVEL_HALF;
    endcase
    t_fin    = invert ? (TRAVEL_FULL - t_sel) : t_sel;
    out_up   = (out_max >= out_min);
    out_span = out_up ? (out_max - out_min) : (out_min - out_max);
  end

  // Result values and button
  logic [PROD_W-1:0]     prod_rnd;
  logic [AXIS_W-1:0]     inc;
  logic [AXIS_W-1:0]     out_new;
  logic                  is_sample;
  logic [TRAVEL_W-1:0]   trav_final;
  logic [AXIS_W-1:0]     axis_final;
  logic signed [TRAVEL_W:0] off_lim;
  logic                  latch_final;
  always_comb begin
    prod_rnd   = prod + ROUND_HALF;
    inc        = prod_rnd[AXIS_W+AXIS_W-1:AXIS_W];
    out_new    = out_up ? (out_min + inc) : (out_min - inc);
    is_sample  = !req_q && ok_q;
    trav_final = is_sample ? trav_q : held_travel;
    axis_final = is_sample ? out_new : held_output;
    off_lim    = $signed({1'b0, button_threshold}) - $signed({1'b0, button_hysteresis});
    if (button_latch) begin
      latch_final = !($signed({1'b0, trav_final}) < off_lim);
    end else begin
      latch_final = (trav_final >= button_threshold);
    end
  end

  // Frame state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      cont_angle   <= '0;
      range_low    <= FRAME_MAX;
      range_high   <= FRAME_MIN;
      prev_raw     <= '0;
      seeded       <= 1'b0;
      upd_range    <= 1'b0;
      held_output  <= AXIS_RESET;
      held_travel  <= TRAVEL_HALF;
      button_latch <= 1'b0;
    end else begin
      if (cmd.unwrap) begin
        upd_range <= 1'b0;
        if (req_q) begin
          range_low  <= FRAME_MAX;
          range_high <= FRAME_MIN;
          seeded     <= 1'b0;
        end else if (ok_q) begin
          if (!seeded) begin
            if (have_stored) begin
              cont_angle <= $signed(FRAME_BITS'(seed_cont));
              range_low  <= $signed(FRAME_BITS'(stored_min_abs));
              range_high <= seed_hi;
            end else begin
              cont_angle <= $signed(FRAME_BITS'(raw_q));
            end
            prev_raw <= raw_q;
            seeded   <= 1'b1;
          end else if (step_ok) begin
            cont_angle <= cont_sat;
            prev_raw   <= raw_q;
            upd_range  <= !have_stored;
          end
        end
      end
      // Grow the observed range
      if (cmd.range_upd && upd_range) begin
        if (cont_angle < range_low)  range_low  <= cont_angle;
        if (cont_angle > range_high) range_high <= cont_angle;
      end
      // Commit held values and button
      if (cmd.finish) begin
        held_travel  <= trav_final;
        held_output  <= axis_final;
        button_latch <= latch_final;
      end
    end
  end

  // Divider and scaling registers
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      if (!has_range) begin
        tmode <= TM_CENTER;
      end else if (num[FRAME_BITS] || (num == '0)) begin
        tmode <= TM_ZERO;
      end else if (num[FRAME_BITS-1:0] >= den) begin
        tmode <= TM_FULL;
      end else begin
        tmode <= TM_DIVIDE;
      end
      div_d   <= {den, 1'b0};
      div_r   <= {1'b0, num[FRAME_BITS-1:0]}
               + DIV_R_W'(den[FRAME_BITS-1:TRAVEL_W]);
      div_lo  <= den[TRAVEL_W-1:0];
      quo     <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      div_r   <= div_ge ? div_diff[DIV_R_W-1:0] : div_rs[DIV_R_W-1:0];
      quo     <= {quo[TRAVEL_W-2:0], div_ge};
      div_lo  <= {div_lo[TRAVEL_W-2:0], 1'b0};
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.scale) begin
      trav_q <= t_fin;
      prod   <= PROD_W'(t_fin) * PROD_W'(out_span);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      axis_value     <= axis_final;
      travel         <= trav_final;
      virtual_button <= latch_final;
      range_valid    <= (range_high > range_low);
    end
  end

  // Status to controller
  always_comb begin
    status.is_sample = is_sample;
    status.div_last  = (div_cnt == DIV_LAST);
    status.out_free  = !out_valid || out_ready;
  end

endmodule
`default_nettype wire
